// ===== design/kbt_pkg.sv =====
package kbt_pkg;

	localparam int WORD_BITS = 64;
	localparam int WIDX_W    = 2;
	localparam int LEN_W     = 8;
	localparam int IDX_W     = 4;
	localparam int COUNT_W   = 5;

	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_REMOVE   = 2'd1,
		CMD_CONTAINS = 2'd2,
		CMD_NOP      = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STS_DONE      = 3'd0,
		STS_SHORT     = 3'd1,
		STS_FULL      = 3'd2,
		STS_NOT_FOUND = 3'd3,
		STS_PRESENT   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_ADD,
		S_RESP
	} state_t;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		logic    ok;
		status_t status;
		idx_t    match_index;
		count_t  entry_count;
	} rsp_t;

endpackage

// ===== design/kbt_req_if.sv =====
interface kbt_req_if;
	logic                              valid;
	logic                              ready;
	kbt_pkg::cmd_t                     command;
	logic [kbt_pkg::WORD_BITS-1:0]     key_word;
	logic [kbt_pkg::WIDX_W-1:0]        word_index;
	logic                              last_word;
	logic [kbt_pkg::LEN_W-1:0]         match_len;

	modport source (output valid, command, key_word, word_index, last_word, match_len,
		input ready);
	modport sink (input valid, command, key_word, word_index, last_word, match_len,
		output ready);
endinterface

// ===== design/kbt_rsp_if.sv =====
interface kbt_rsp_if;
	logic             valid;
	logic             ready;
	logic             ok;
	kbt_pkg::status_t status;
	kbt_pkg::idx_t    match_index;
	kbt_pkg::count_t  entry_count;

	modport source (output valid, ok, status, match_index, entry_count, input ready);
	modport sink (input valid, ok, status, match_index, entry_count, output ready);
endinterface

// ===== design/kbt_store.sv =====
module kbt_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic [kbt_pkg::WORD_BITS-1:0]     wdata,
	input  logic [AW-1:0]                     raddr,
	output logic [kbt_pkg::WORD_BITS-1:0]     rdata
);

	logic [kbt_pkg::WORD_BITS-1:0] mem [DEPTH];
	logic [kbt_pkg::WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/kbt_word_cmp.sv =====
// Byte-masked compare of one key word; only bytes below len take part.
module kbt_word_cmp #(
	parameter int WW = 2,
	parameter int LW = 6
) (
	input  logic [kbt_pkg::WORD_BITS-1:0] a,
	input  logic [kbt_pkg::WORD_BITS-1:0] b,
	input  logic [WW-1:0]                 word,
	input  logic [LW-1:0]                 len,
	output logic                          eq
);

	always_comb begin
		eq = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (((int'(word) * 8 + i) < int'(len)) &&
			    (a[63 - 8 * i -: 8] != b[63 - 8 * i -: 8])) begin
				eq = 1'b0;
			end
		end
	end

endmodule

// ===== design/key_blocklist_table.sv =====
// channel  dir  fields                                           transfer
// req      in   command key_word word_index last_word match_len  valid & ready
// rsp      out  ok status match_index entry_count                valid & ready
//
// A non-final word (or an unused command) only latches its word. Add scans up
// to live*KW words (KW = 64-bit words per key), then writes KW if the key is new
// and the table has room; remove and contains scan to the first hit, and remove
// then copies the later entries down one word a cycle. A short add or an empty
// table search goes straight to the response.
// Reset clears count and control only. req is not ready while a command runs.
module key_blocklist_table #(
	parameter int ENTRIES   = 16,
	parameter int KEY_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	kbt_req_if.sink     req,
	kbt_rsp_if.source   rsp
);

	localparam int KW    = (KEY_BYTES + 7) / 8;
	localparam int WW    = (KW > 1) ? $clog2(KW) : 1;
	localparam int DEPTH = ENTRIES * KW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = $clog2(DEPTH + 1);
	localparam int EIW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam int LW    = $clog2(KEY_BYTES + 1);

	kbt_pkg::state_t state_q, state_d;

	logic [kbt_pkg::WORD_BITS-1:0] asm_q [KW];
	kbt_pkg::cmd_t  cmd_q;
	logic [LW-1:0]  len_q;
	logic [CW-1:0]  live_q;
	logic [EIW-1:0] entry_q;
	logic [WW-1:0]  word_q;
	logic [EW-1:0]  addr_q;
	logic [EW-1:0]  end_q;
	logic           issue_done_q;
	logic           acc_q;

	logic           v_s1;
	logic [WW-1:0]  word_s1;
	logic [EIW-1:0] entry_s1;
	logic           lastw_s1;
	logic           lasten_s1;
	logic [EW-1:0]  addr_s1;
	logic           wv_s1;
	logic [AW-1:0]  waddr_s1;

	kbt_pkg::rsp_t  res_q;
	kbt_pkg::rsp_t  out_q;
	logic           out_valid_q;

	logic                          accept, go, issue, shift_issue, resp_fire;
	logic                          eq, m, hit_now, miss_now, short_add;
	logic [LW-1:0]                 len_c;
	logic [EW-1:0]                 base;
	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [kbt_pkg::WORD_BITS-1:0] mem_wdata, mem_rdata;

	kbt_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (AW'(addr_q)),
		.rdata (mem_rdata)
	);

	kbt_word_cmp #(.WW(WW), .LW(LW)) u_cmp (
		.a    (mem_rdata),
		.b    (asm_q[word_s1]),
		.word (word_s1),
		.len  (len_q),
		.eq   (eq)
	);

	assign accept    = req.valid && req.ready;
	assign go        = accept && req.last_word && (req.command != kbt_pkg::CMD_NOP);
	assign len_c     = (int'(req.match_len) > KEY_BYTES) ? LW'(KEY_BYTES) : LW'(req.match_len);
	assign short_add = (req.command == kbt_pkg::CMD_ADD) && (int'(len_c) < KEY_BYTES);
	assign base      = EW'(live_q * KW);

	// Running AND over the words of one entry
	assign m        = eq && ((word_s1 == WW'(0)) || acc_q);
	assign hit_now  = v_s1 && lastw_s1 && m;
	assign miss_now = v_s1 && lastw_s1 && lasten_s1 && !m;

	assign issue       = (state_q == kbt_pkg::S_SCAN) && !issue_done_q && !hit_now && !miss_now;
	assign shift_issue = (state_q == kbt_pkg::S_SHIFT) && (addr_q != end_q);
	assign resp_fire   = (state_q == kbt_pkg::S_RESP) && (!out_valid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			kbt_pkg::S_IDLE: begin
				if (go) begin
					if (short_add) begin
						state_d = kbt_pkg::S_RESP;
					end else if (live_q == CW'(0)) begin
						state_d = (req.command == kbt_pkg::CMD_ADD) ? kbt_pkg::S_ADD
							: kbt_pkg::S_RESP;
					end else begin
						state_d = kbt_pkg::S_SCAN;
					end
				end
			end
			kbt_pkg::S_SCAN: begin
				if (hit_now) begin
					state_d = (cmd_q == kbt_pkg::CMD_REMOVE) ? kbt_pkg::S_SHIFT
						: kbt_pkg::S_RESP;
				end else if (miss_now) begin
					state_d = ((cmd_q == kbt_pkg::CMD_ADD) && (int'(live_q) < ENTRIES))
						? kbt_pkg::S_ADD : kbt_pkg::S_RESP;
				end
			end
			kbt_pkg::S_SHIFT: begin
				if ((addr_q == end_q) && !wv_s1) begin
					state_d = kbt_pkg::S_RESP;
				end
			end
			kbt_pkg::S_ADD: begin
				if (word_q == WW'(KW - 1)) begin
					state_d = kbt_pkg::S_RESP;
				end
			end
			kbt_pkg::S_RESP: begin
				if (resp_fire) begin
					state_d = kbt_pkg::S_IDLE;
				end
			end
			default: state_d = kbt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = AW'(addr_q);
		mem_wdata = asm_q[word_q];
		case (state_q)
			kbt_pkg::S_IDLE: begin
				req.ready = 1'b1;
			end
			kbt_pkg::S_ADD: begin
				mem_we = 1'b1;
			end
			kbt_pkg::S_SHIFT: begin
				mem_we    = wv_s1;
				mem_waddr = waddr_s1;
				mem_wdata = mem_rdata;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kbt_pkg::S_IDLE;
			live_q       <= '0;
			issue_done_q <= 1'b0;
			v_s1         <= 1'b0;
			wv_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			wv_s1   <= shift_issue;
			if (go) begin
				issue_done_q <= 1'b0;
			end else if (issue && (word_q == WW'(KW - 1)) &&
			             ((CW'(entry_q) + CW'(1)) == live_q)) begin
				issue_done_q <= 1'b1;
			end
			if ((state_q == kbt_pkg::S_ADD) && (word_q == WW'(KW - 1))) begin
				live_q <= live_q + CW'(1);
			end else if (hit_now && (cmd_q == kbt_pkg::CMD_REMOVE)) begin
				live_q <= live_q - CW'(1);
			end
			if (resp_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (int'(req.word_index) < KW)) begin
			asm_q[WW'(req.word_index)] <= req.key_word;
		end

		if (go) begin
			cmd_q   <= req.command;
			len_q   <= len_c;
			entry_q <= '0;
			word_q  <= '0;
			addr_q  <= '0;
			res_q   <= '{ok: 1'b0,
				status: short_add ? kbt_pkg::STS_SHORT : kbt_pkg::STS_NOT_FOUND,
				match_index: '0, entry_count: kbt_pkg::count_t'(live_q)};
		end

		if (issue) begin
			word_s1   <= word_q;
			entry_s1  <= entry_q;
			lastw_s1  <= (word_q == WW'(KW - 1));
			lasten_s1 <= ((CW'(entry_q) + CW'(1)) == live_q);
			addr_s1   <= addr_q;
			addr_q    <= addr_q + EW'(1);
			if (word_q == WW'(KW - 1)) begin
				word_q  <= '0;
				entry_q <= entry_q + EIW'(1);
			end else begin
				word_q <= word_q + WW'(1);
			end
		end

		if (v_s1) begin
			acc_q <= m;
		end

		if (hit_now) begin
			res_q.ok          <= 1'b1;
			res_q.status      <= (cmd_q == kbt_pkg::CMD_ADD) ? kbt_pkg::STS_PRESENT
				: kbt_pkg::STS_DONE;
			res_q.match_index <= kbt_pkg::idx_t'(entry_s1);
			res_q.entry_count <= (cmd_q == kbt_pkg::CMD_REMOVE)
				? kbt_pkg::count_t'(live_q - CW'(1)) : kbt_pkg::count_t'(live_q);
			// Later entries move down from the word after the hit
			addr_q <= addr_s1 + EW'(1);
			end_q  <= base;
		end else if (miss_now) begin
			if ((cmd_q == kbt_pkg::CMD_ADD) && (int'(live_q) < ENTRIES)) begin
				addr_q <= base;
				word_q <= '0;
			end else begin
				res_q <= '{ok: 1'b0,
					status: (cmd_q == kbt_pkg::CMD_ADD) ? kbt_pkg::STS_FULL
						: kbt_pkg::STS_NOT_FOUND,
					match_index: '0, entry_count: kbt_pkg::count_t'(live_q)};
			end
		end

		if (shift_issue) begin
			waddr_s1 <= AW'(addr_q - EW'(KW));
			addr_q   <= addr_q + EW'(1);
		end

		if (state_q == kbt_pkg::S_ADD) begin
			addr_q <= addr_q + EW'(1);
			word_q <= word_q + WW'(1);
			if (word_q == WW'(KW - 1)) begin
				res_q <= '{ok: 1'b1, status: kbt_pkg::STS_DONE,
					match_index: kbt_pkg::idx_t'(live_q),
					entry_count: kbt_pkg::count_t'(live_q + CW'(1))};
			end
		end

		if (resp_fire) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.ok          = out_q.ok;
	assign rsp.status      = out_q.status;
	assign rsp.match_index = out_q.match_index;
	assign rsp.entry_count = out_q.entry_count;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import kbt_pkg::*;

	localparam int ENTRIES     = 16;
	localparam int KEY_BYTES   = 32;
	localparam int KEY_BITS    = KEY_BYTES * 8;
	localparam int KEY_WORDS   = KEY_BYTES / 8;
	localparam int POOL        = 24;
	localparam int ITEM_TARGET = 650;
	localparam int QUIET_LIMIT = 4000;
	localparam int END_WAIT    = 200;
	localparam logic [7:0] FULL_LEN = 8'(KEY_BYTES);

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	kbt_req_if req();
	kbt_rsp_if rsp();

	key_blocklist_table #(
		.ENTRIES   (ENTRIES),
		.KEY_BYTES (KEY_BYTES)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #10 clk = ~clk;

	// shadow of the table: key byte 0 sits in the top bits
	logic [KEY_BITS-1:0] shadow_keys [ENTRIES];
	logic [KEY_BITS-1:0] shadow_assembly;
	int                  shadow_live;
	logic [KEY_BITS-1:0] key_pool [POOL];

	rsp_t pending_rsp [$];

	bit idle_on = 1'b1;
	int hold_len;
	int hold_seq;
	int err_count;
	int items_sent;
	int peak_live;
	int status_seen [5];

	function automatic logic [KEY_BITS-1:0] rand_key();
		logic [KEY_BITS-1:0] k;
		for (int i = 0; i < KEY_BITS / 32; i++)
			k[KEY_BITS-1-32*i -: 32] = $urandom;
		return k;
	endfunction

	function automatic int find_prefix(int len);
		logic [KEY_BITS-1:0] mask;
		mask = '0;
		if (len > 0)
			mask = {KEY_BITS{1'b1}} << (KEY_BITS - 8 * len);
		for (int i = 0; i < shadow_live && i < ENTRIES; i++) begin
			if (((shadow_keys[i] ^ shadow_assembly) & mask) == '0)
				return i;
		end
		return -1;
	endfunction

	// latches the word, runs the command on a final word; 1 when a response is due
	function automatic bit table_apply(cmd_t cmd, logic [63:0] word, logic [1:0] widx,
		logic last, logic [7:0] mlen, output rsp_t r);
		int len;
		int hit;
		shadow_assembly[KEY_BITS-1-64*widx -: 64] = word;
		r = '0;
		if (!last || cmd == CMD_NOP)
			return 1'b0;
		len = (mlen > KEY_BYTES) ? KEY_BYTES : int'(mlen);
		r.status = STS_DONE;
		case (cmd)
			CMD_ADD: begin
				if (len < KEY_BYTES) begin
					r.status = STS_SHORT;
				end else begin
					hit = find_prefix(KEY_BYTES);
					if (hit >= 0) begin
						r.ok          = 1'b1;
						r.status      = STS_PRESENT;
						r.match_index = idx_t'(hit);
					end else if (shadow_live >= ENTRIES) begin
						r.status = STS_FULL;
					end else begin
						shadow_keys[shadow_live] = shadow_assembly;
						r.ok          = 1'b1;
						r.match_index = idx_t'(shadow_live);
						shadow_live++;
					end
				end
			end
			CMD_REMOVE: begin
				hit = find_prefix(len);
				if (hit < 0) begin
					r.status = STS_NOT_FOUND;
				end else begin
					r.ok          = 1'b1;
					r.match_index = idx_t'(hit);
					shadow_live--;
					for (int i = hit; i < shadow_live; i++)
						shadow_keys[i] = shadow_keys[i+1];
				end
			end
			default: begin
				hit = find_prefix(len);
				if (hit < 0) begin
					r.status = STS_NOT_FOUND;
				end else begin
					r.ok          = 1'b1;
					r.match_index = idx_t'(hit);
				end
			end
		endcase
		r.entry_count = count_t'(shadow_live);
		if (shadow_live > peak_live)
			peak_live = shadow_live;
		return 1'b1;
	endfunction

	function automatic cmd_t pick_cmd();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return CMD_ADD;
		if (r < 7)
			return CMD_REMOVE;
		return CMD_CONTAINS;
	endfunction

	function automatic logic [7:0] pick_len(int nwords);
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return 8'($urandom_range(0, 8 * nwords));
		if (r < 17)
			return FULL_LEN;
		return 8'($urandom_range(KEY_BYTES + 1, 255));
	endfunction

	// valid stays high across back-to-back transfers
	task automatic send_word(cmd_t cmd, logic [63:0] word, logic [1:0] widx, logic last,
		logic [7:0] mlen);
		int   gap;
		rsp_t want;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.command    <= cmd;
		req.key_word   <= word;
		req.word_index <= widx;
		req.last_word  <= last;
		req.match_len  <= mlen;
		do @(posedge clk); while (!req.ready);
		if (table_apply(cmd, word, widx, last, mlen, want))
			pending_rsp.push_back(want);
		items_sent++;
	endtask

	task automatic send_key(cmd_t cmd, logic [KEY_BITS-1:0] k, int nwords, int first,
		logic with_last, logic [7:0] mlen);
		int w;
		for (int j = 0; j < nwords; j++) begin
			w = (first + j) % KEY_WORDS;
			send_word(cmd, k[KEY_BITS-1-64*w -: 64], w[1:0], with_last && (j == nwords - 1),
				mlen);
		end
	endtask

	task automatic wait_for_responses();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
		if (seen !== want) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
		end
	endfunction

	task automatic test_add_key();
		logic [KEY_BITS-1:0] ka;
		ka = rand_key();
		send_key(CMD_ADD, ka, KEY_WORDS, 0, 1'b1, FULL_LEN);
		send_word(CMD_ADD, ka[63:0], 2'd3, 1'b1, 8'd255);   // duplicate
		send_word(CMD_ADD, ka[63:0], 2'd3, 1'b1, FULL_LEN - 8'd1);   // too short
		send_key(CMD_ADD, {KEY_BITS{1'b1}}, KEY_WORDS, 0, 1'b1, FULL_LEN);
		send_key(CMD_ADD, {KEY_BITS{1'b0}}, KEY_WORDS, 0, 1'b1, FULL_LEN);
	endtask

	task automatic test_prefix_lookup();
		send_word(CMD_CONTAINS, 64'h0, 2'd0, 1'b1, 8'd0);
		send_word(CMD_CONTAINS, '1, 2'd0, 1'b1, 8'd8);
		send_word(CMD_CONTAINS, '1, 2'd0, 1'b1, 8'd9);
		send_word(CMD_CONTAINS, 64'h0, 2'd0, 1'b1, 8'd200);
	endtask

	task automatic test_remove_prefix();
		send_word(CMD_REMOVE, 64'h0, 2'd0, 1'b1, 8'd0);
		send_word(CMD_REMOVE, '1, 2'd0, 1'b1, 8'd8);
		send_word(CMD_REMOVE, '1, 2'd0, 1'b1, FULL_LEN);
		send_word(CMD_REMOVE, 64'h0, 2'd0, 1'b1, FULL_LEN);
		send_word(CMD_REMOVE, 64'h0, 2'd0, 1'b1, 8'd0);   // empty table
		send_word(CMD_CONTAINS, 64'h0, 2'd0, 1'b1, 8'd0);
	endtask

	task automatic test_unused_command();
		send_word(CMD_NOP, {$urandom, $urandom}, 2'd1, 1'b1, FULL_LEN);
		send_word(CMD_NOP, {$urandom, $urandom}, 2'd2, 1'b0, 8'd255);
		send_word(CMD_REMOVE, {$urandom, $urandom}, 2'd3, 1'b0, FULL_LEN);
		wait_for_responses();
	endtask

	task automatic test_table_full();
		logic [KEY_BITS-1:0] base;
		logic [63:0]         spare;
		base  = rand_key();
		spare = {$urandom, $urandom};
		send_key(CMD_ADD, base, KEY_WORDS, 0, 1'b1, FULL_LEN);
		while (shadow_live < ENTRIES)
			send_word(CMD_ADD, {$urandom, $urandom}, 2'd3, 1'b1, FULL_LEN);
		send_word(CMD_ADD, spare, 2'd3, 1'b1, FULL_LEN);
		// shared leading 24 bytes: hits entry 0, so removal compacts the whole table
		send_word(CMD_CONTAINS, base[KEY_BITS-1 -: 64], 2'd0, 1'b1, 8'd24);
		send_word(CMD_REMOVE, base[KEY_BITS-1 -: 64], 2'd0, 1'b1, 8'd24);
		send_word(CMD_ADD, spare, 2'd3, 1'b1, FULL_LEN);
		wait_for_responses();
	endtask

	task automatic test_backpressure();
		logic [KEY_BITS-1:0] k;
		hold_len = 300;
		hold_seq++;
		idle_on  = 1'b0;
		repeat (6) begin
			k = rand_key();
			send_key(($urandom_range(0, 1) != 0) ? CMD_ADD : CMD_CONTAINS, k, KEY_WORDS, 0,
				1'b1, FULL_LEN);
		end
		idle_on = 1'b1;
		wait_for_responses();
	endtask

	task automatic test_random_traffic();
		logic [KEY_BITS-1:0] k;
		logic [KEY_BITS-1:0] mask;
		int                  sel;
		int                  nw;
		int                  next_toggle;
		int                  next_pause;
		cmd_t                cmd;
		logic [7:0]          mlen;
		// odd pool keys share a random-length prefix with their neighbour
		for (int p = 0; p < POOL; p++) begin
			key_pool[p] = rand_key();
			if (p % 2 == 1) begin
				nw          = $urandom_range(1, KEY_BYTES - 1);
				mask        = {KEY_BITS{1'b1}} << (KEY_BITS - 8 * nw);
				key_pool[p] = (key_pool[p-1] & mask) | (key_pool[p] & ~mask);
			end
		end
		next_toggle = items_sent + 100;
		next_pause  = items_sent + 170;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= next_toggle) begin
				idle_on     = !idle_on;
				next_toggle = items_sent + $urandom_range(60, 140);
			end
			if (items_sent >= next_pause) begin
				wait_for_responses();
				next_pause = items_sent + $urandom_range(120, 220);
			end
			sel = $urandom_range(0, 99);
			k   = ($urandom_range(0, 4) == 0) ? rand_key() : key_pool[$urandom_range(0, POOL - 1)];
			if (sel < 45) begin
				cmd = pick_cmd();
				if (cmd == CMD_ADD)
					mlen = ($urandom_range(0, 9) == 0) ? pick_len(KEY_WORDS) : FULL_LEN;
				else
					mlen = ($urandom_range(0, 1) == 0) ? FULL_LEN : pick_len(KEY_WORDS);
				send_key(cmd, k, KEY_WORDS, $urandom_range(0, KEY_WORDS - 1), 1'b1, mlen);
			end else if (sel < 65) begin
				nw  = $urandom_range(1, KEY_WORDS - 1);
				cmd = ($urandom_range(0, 1) != 0) ? CMD_REMOVE : CMD_CONTAINS;
				send_key(cmd, k, nw, 0, 1'b1, pick_len(nw));
			end else if (sel < 75) begin
				send_word(CMD_ADD, {$urandom, $urandom}, 2'd3, 1'b1, FULL_LEN);
			end else if (sel < 90) begin
				send_word(cmd_t'($urandom_range(0, 3)), {$urandom, $urandom},
					2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)));
			end else begin
				// broken sequences: never closed, or closed with the unused code
				nw = $urandom_range(1, KEY_WORDS);
				if ($urandom_range(0, 1) != 0)
					send_key(CMD_NOP, k, nw, 0, 1'b1, FULL_LEN);
				else
					send_key(pick_cmd(), k, nw, 0, 1'b0, FULL_LEN);
			end
		end
		idle_on = 1'b1;
	endtask

	// response sink: random gaps per transfer, plus an occasional long hold-off
	initial begin : rsp_sink
		int stall_left;
		int gap_left;
		int hold_seen;
		stall_left = 0;
		gap_left   = 0;
		hold_seen  = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen  = hold_seq;
				stall_left = hold_len;
			end
			if (rsp.valid && rsp.ready)
				gap_left = idle_on ? $urandom_range(0, 7) : 0;
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.ok          = rsp.ok;
			got.status      = rsp.status;
			got.match_index = rsp.match_index;
			got.entry_count = rsp.entry_count;
			if (pending_rsp.size() == 0) begin
				err_count++;
				$display("%0t: unexpected response, expected none, got ok %0b status %0d index %0d count %0d",
					$time, got.ok, got.status, got.match_index, got.entry_count);
			end else begin
				want = pending_rsp.pop_front();
				check_field("ok", 8'(want.ok), 8'(got.ok));
				check_field("status", 8'(want.status), 8'(got.status));
				check_field("match_index", 8'(want.match_index), 8'(got.match_index));
				check_field("entry_count", 8'(want.entry_count), 8'(got.entry_count));
			end
			if (!$isunknown(got.status) && got.status <= STS_PRESENT)
				status_seen[int'(got.status)]++;
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		req.valid      <= 1'b0;
		req.command    <= CMD_ADD;
		req.key_word   <= '0;
		req.word_index <= '0;
		req.last_word  <= 1'b0;
		req.match_len  <= '0;
		shadow_live     = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_add_key();
		test_prefix_lookup();
		test_remove_prefix();
		test_unused_command();
		test_table_full();
		test_backpressure();
		test_random_traffic();

		wait_for_responses();
		repeat (END_WAIT) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			err_count++;
			$display("%0t: %0d responses never arrived", $time, pending_rsp.size());
		end
		$display("Covered %0d request transfers: %0d done, %0d short, %0d full, %0d not found, %0d present",
			items_sent, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4]);
		$display("Table peaked at %0d of %0d entries, with output hold-off and drain pauses",
			peak_live, ENTRIES);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/kbt_pkg.sv
design/kbt_req_if.sv
design/kbt_rsp_if.sv
design/kbt_store.sv
design/kbt_word_cmp.sv
design/key_blocklist_table.sv
bench/tb_top.sv
